@@ rtl/bcd_clock_minute_offset_adjust_core_defines.svh @@
// ----------------------------------------------------------------------------
// bcd_clock_minute_offset_adjust_core_defines.svh
// Assertion macros for the BCD clock offset core.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_MINUTE_OFFSET_ADJUST_CORE_DEFINES_SVH
`define BCD_CLOCK_MINUTE_OFFSET_ADJUST_CORE_DEFINES_SVH

// ante implies cons in the same cycle
`define BCMOA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcmoa assertion failed");

// expr must never be true
`define BCMOA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bcmoa assertion failed");

`endif

@@ rtl/bcmoa_pkg.sv @@
// ----------------------------------------------------------------------------
// bcmoa_pkg
// Types, constants and calendar helpers for the BCD clock offset core.
// ----------------------------------------------------------------------------
package bcmoa_pkg;

	localparam int LATENCY = 7;
	localparam logic [12:0] TOTAL_BIAS = 13'd2100; // 35 hours of minutes
	localparam logic [7:0] HOUR_BIAS = 8'd35;

	typedef struct packed {
		logic [7:0] second_in;
		logic [7:0] minute_in;
		logic [7:0] hour_in;
		logic [7:0] day_in;
		logic [7:0] month_in;
		logic [7:0] year_in;
		logic signed [11:0] offset_minutes;
	} item_t;

	typedef struct packed {
		logic [7:0] second_out;
		logic [7:0] minute_out;
		logic [7:0] hour_out;
		logic [7:0] day_out;
		logic [7:0] month_out;
		logic [7:0] year_out;
		logic bad_month;
	} result_t;

	typedef struct packed {
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] year;
	} date_t;

	function automatic logic [7:0] bcd_dec(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return 8'(b - (hi << 2) - (hi << 1));
	endfunction

	function automatic logic [7:0] bcd_enc(input logic [7:0] d);
		logic [15:0] prod;
		logic [7:0] tens;
		prod = {8'd0, d} * 16'd205;
		tens = 8'(prod >> 11);
		return 8'(d + (tens << 2) + (tens << 1));
	endfunction

	function automatic logic [7:0] days_of(input logic [7:0] month, input logic [7:0] year);
		logic [7:0] m;
		m = 8'(month - 8'd1);
		if (m > 8'd11) return 8'd31;
		case (m)
			8'd1: return (year[1:0] == 2'd0) ? 8'd29 : 8'd28;
			8'd3, 8'd5, 8'd8, 8'd10: return 8'd30;
			default: return 8'd31;
		endcase
	endfunction

	function automatic date_t next_day(input date_t c);
		date_t r;
		logic [7:0] lim;
		r = c;
		lim = days_of(c.month, c.year);
		r.day = 8'(c.day + 8'd1);
		if (r.day > lim) begin
			r.day = 8'd1;
			r.month = 8'(c.month + 8'd1);
			if (r.month == 8'd13) begin
				r.month = 8'd1;
				r.year = 8'(c.year + 8'd1);
				if (r.year == 8'd100) r.year = 8'd0;
			end
		end
		return r;
	endfunction

	function automatic date_t prev_day(input date_t c);
		date_t r;
		r = c;
		r.day = 8'(c.day - 8'd1);
		if (r.day == 8'd0) begin
			r.month = 8'(c.month - 8'd1);
			if (r.month == 8'd0) begin
				r.month = 8'd12;
				r.year = (c.year == 8'd0) ? 8'd99 : 8'(c.year - 8'd1);
			end
			r.day = days_of(r.month, r.year);
		end
		return r;
	endfunction

endpackage

@@ rtl/bcd_clock_minute_offset_adjust_core.sv @@
// ----------------------------------------------------------------------------
// bcd_clock_minute_offset_adjust_core
// Adds a signed minute offset to a BCD clock reading, rolling hours and date.
// ----------------------------------------------------------------------------
// A reading is taken whenever start is high; busy stays low, so a new beat can
// enter every cycle. The result appears on result with done high exactly
// seven cycles later, for one cycle, and must be captured then. The latency
// is set by the seven-stage pipeline: decode, divide-by-60 multiply, remainder
// fixup, hour roll, two day steps (an offset moves the date by at most two
// days), and BCD encode. A decoded month outside 1..12 freezes the date and
// sets bad_month; minutes and hours are still adjusted.
module bcd_clock_minute_offset_adjust_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bcmoa_pkg::item_t    item,
	output logic                done,
	output bcmoa_pkg::result_t  result
);

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, done_q;

	// stage 1: decode, biased total minutes (total + 2100, always positive)
	logic [7:0]  sec_s1, hour_s1;
	bcmoa_pkg::date_t date_s1;
	logic [12:0] t_s1;
	// stage 2: quotient estimate
	logic [7:0]  sec_s2, hour_s2;
	bcmoa_pkg::date_t date_s2;
	logic [12:0] t_s2;
	logic [6:0]  q_s2;
	// stage 3: hour step count and minutes
	logic [7:0]  sec_s3, hour_s3, min_s3;
	bcmoa_pkg::date_t date_s3;
	logic signed [7:0] n_s3;
	// stage 4: final hour and day moves (-2..2)
	logic [7:0]  sec_s4, hour_s4, min_s4;
	bcmoa_pkg::date_t date_s4;
	logic signed [2:0] dd_s4;
	logic ok_s4;
	// stages 5, 6: day steps
	logic [7:0]  sec_s5, hour_s5, min_s5, sec_s6, hour_s6, min_s6;
	bcmoa_pkg::date_t date_s5, date_s6;
	logic signed [2:0] dd_s5;
	logic ok_s5, ok_s6;
	bcmoa_pkg::result_t res_q;

	logic [12:0] total_c;
	logic [22:0] prod_c;
	logic [12:0] rem_c;
	logic [6:0]  q_c;
	logic [7:0]  hour_c;
	logic signed [2:0] dd_c;
	logic [7:0]  k_c, r_c, s_c;
	logic        ok_c;
	bcmoa_pkg::date_t date5_c, date6_c;

	assign busy = 1'b0;

	// stage 1 input math
	always_comb begin
		total_c = 13'(13'($signed(item.offset_minutes))
			+ {5'd0, bcmoa_pkg::bcd_dec(item.minute_in)} + bcmoa_pkg::TOTAL_BIAS);
	end

	// stage 2: t/60 = (t/4)/15, 1/15 ~ 2185/32768, off by at most one
	always_comb begin
		prod_c = 23'({12'd0, t_s1[12:2]} * 23'd2185);
	end

	// stage 3: remainder and one-step fixup
	always_comb begin
		rem_c = 13'(t_s2 - ({6'd0, q_s2} << 6) + ({6'd0, q_s2} << 2));
		q_c = q_s2;
		if (rem_c >= 13'd60) begin
			rem_c = 13'(rem_c - 13'd60);
			q_c = 7'(q_s2 + 7'd1);
		end
	end

	// stage 4: closed-form hour roll
	always_comb begin
		hour_c = hour_s3;
		dd_c = 3'sd0;
		k_c = 8'(-n_s3);
		r_c = 8'd0;
		s_c = 8'(hour_s3 + n_s3);
		if (n_s3 >= 0) begin
			if (hour_s3 < 8'd24) begin
				if (s_c >= 8'd48) begin
					dd_c = 3'sd2;
					hour_c = 8'(s_c - 8'd48);
				end else if (s_c >= 8'd24) begin
					dd_c = 3'sd1;
					hour_c = 8'(s_c - 8'd24);
				end else begin
					hour_c = s_c;
				end
			end else begin
				hour_c = s_c; // no wrap possible in range
			end
		end else if (k_c <= hour_s3) begin
			hour_c = 8'(hour_s3 - k_c);
		end else begin
			r_c = 8'(k_c - hour_s3 - 8'd1);
			if (r_c >= 8'd24) begin
				dd_c = -3'sd2;
				hour_c = 8'(8'd47 - r_c);
			end else begin
				dd_c = -3'sd1;
				hour_c = 8'(8'd23 - r_c);
			end
		end
	end

	always_comb begin
		ok_c = (date_s3.month >= 8'd1) && (date_s3.month <= 8'd12);
		date5_c = date_s4;
		if (ok_s4 && dd_s4 > 0) date5_c = bcmoa_pkg::next_day(date_s4);
		else if (ok_s4 && dd_s4 < 0) date5_c = bcmoa_pkg::prev_day(date_s4);
		date6_c = date_s5;
		if (ok_s5 && dd_s5 == 3'sd2) date6_c = bcmoa_pkg::next_day(date_s5);
		else if (ok_s5 && dd_s5 == -3'sd2) date6_c = bcmoa_pkg::prev_day(date_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; done_q <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1 <= bcmoa_pkg::bcd_dec(item.second_in);
		hour_s1 <= bcmoa_pkg::bcd_dec(item.hour_in);
		date_s1 <= '{day: bcmoa_pkg::bcd_dec(item.day_in),
			month: bcmoa_pkg::bcd_dec(item.month_in),
			year: bcmoa_pkg::bcd_dec(item.year_in)};
		t_s1 <= total_c;

		sec_s2 <= sec_s1; hour_s2 <= hour_s1; date_s2 <= date_s1; t_s2 <= t_s1;
		q_s2 <= prod_c[21:15];

		sec_s3 <= sec_s2; hour_s3 <= hour_s2; date_s3 <= date_s2;
		min_s3 <= rem_c[7:0];
		n_s3 <= 8'($signed({1'b0, q_c}) - $signed(bcmoa_pkg::HOUR_BIAS));

		sec_s4 <= sec_s3; min_s4 <= min_s3; date_s4 <= date_s3;
		hour_s4 <= hour_c; dd_s4 <= dd_c; ok_s4 <= ok_c;

		sec_s5 <= sec_s4; min_s5 <= min_s4; hour_s5 <= hour_s4;
		date_s5 <= date5_c; dd_s5 <= dd_s4; ok_s5 <= ok_s4;

		sec_s6 <= sec_s5; min_s6 <= min_s5; hour_s6 <= hour_s5;
		date_s6 <= date6_c; ok_s6 <= ok_s5;

		res_q.second_out <= bcmoa_pkg::bcd_enc(sec_s6);
		res_q.minute_out <= bcmoa_pkg::bcd_enc(min_s6);
		res_q.hour_out <= bcmoa_pkg::bcd_enc(hour_s6);
		res_q.day_out <= bcmoa_pkg::bcd_enc(date_s6.day);
		res_q.month_out <= bcmoa_pkg::bcd_enc(date_s6.month);
		res_q.year_out <= bcmoa_pkg::bcd_enc(date_s6.year);
		res_q.bad_month <= !ok_s6;
	end

	assign done = done_q;
	assign result = res_q;

endmodule

@@ rtl/bcmoa_checker.sv @@
// ----------------------------------------------------------------------------
// bcmoa_checker
// Port-level checks for the BCD clock offset core.
// ----------------------------------------------------------------------------
`include "bcd_clock_minute_offset_adjust_core_defines.svh"

module bcmoa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input bcmoa_pkg::item_t    item,
	input logic                done,
	input bcmoa_pkg::result_t  result
);

	logic [7:0] month_d;
	assign month_d = bcmoa_pkg::bcd_dec(item.month_in);

	`BCMOA_ASSERT_NEVER(a_never_busy, busy)
	`BCMOA_ASSERT_IMP(a_done_latency, done, $past(start, bcmoa_pkg::LATENCY))
	`BCMOA_ASSERT_IMP(a_bad_month, done,
		result.bad_month == $past(month_d < 8'd1 || month_d > 8'd12, bcmoa_pkg::LATENCY))
	`BCMOA_ASSERT_IMP(a_seconds, done, result.second_out ==
		$past(bcmoa_pkg::bcd_enc(bcmoa_pkg::bcd_dec(item.second_in)), bcmoa_pkg::LATENCY))

endmodule

bind bcd_clock_minute_offset_adjust_core bcmoa_checker u_bcmoa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.item(item), .done(done), .result(result)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCD clock offset core: drives readings with
// random gaps, predicts each adjusted reading and compares it with the beat
// that comes out on done.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bcmoa_pkg::item_t item;
	logic done;
	bcmoa_pkg::result_t result;

	bcmoa_pkg::result_t pending_readings[$];
	int mismatch_count;
	int idle_cycles;
	int send_gap_pct;

	bcd_clock_minute_offset_adjust_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---- predictor -------------------------------------------------------
	function automatic logic [7:0] unpack_bcd(input logic [7:0] b);
		return 8'(b - (b >> 4) * 6);
	endfunction

	function automatic logic [7:0] pack_bcd(input logic [7:0] d);
		return 8'(d + (d / 10) * 6);
	endfunction

	function automatic logic [7:0] month_days(input logic [7:0] mon, input logic [7:0] yr);
		logic [7:0] m;
		m = 8'(mon - 1);
		if (m > 11) return 8'd31;
		if (m == 1) return (yr[1:0] == 2'd0) ? 8'd29 : 8'd28;
		if (m == 3 || m == 5 || m == 8 || m == 10) return 8'd30;
		return 8'd31;
	endfunction

	function automatic bcmoa_pkg::result_t adjust_reading(input bcmoa_pkg::item_t it);
		bcmoa_pkg::result_t r;
		logic [7:0] hr, dy, mo, yr, lim;
		logic ok;
		int total;
		hr = unpack_bcd(it.hour_in);
		dy = unpack_bcd(it.day_in);
		mo = unpack_bcd(it.month_in);
		yr = unpack_bcd(it.year_in);
		ok = (mo >= 1 && mo <= 12);
		total = int'(it.offset_minutes) + int'(unpack_bcd(it.minute_in));
		while (total >= 60) begin
			hr = 8'(hr + 1);
			if (hr == 24) begin
				hr = 0;
				if (ok) begin
					lim = month_days(mo, yr);
					dy = 8'(dy + 1);
					if (dy > lim) begin
						dy = 1;
						mo = 8'(mo + 1);
						if (mo == 13) begin
							mo = 1;
							yr = 8'(yr + 1);
							if (yr == 100) yr = 0;
						end
					end
				end
			end
			total -= 60;
		end
		while (total < 0) begin
			if (hr == 0) begin
				hr = 23;
				if (ok) begin
					dy = 8'(dy - 1);
					if (dy == 0) begin
						mo = 8'(mo - 1);
						if (mo == 0) begin
							mo = 12;
							yr = (yr == 0) ? 8'd99 : 8'(yr - 1);
						end
						dy = month_days(mo, yr);
					end
				end
			end else begin
				hr = 8'(hr - 1);
			end
			total += 60;
		end
		r.second_out = pack_bcd(unpack_bcd(it.second_in));
		r.minute_out = pack_bcd(8'(total));
		r.hour_out = pack_bcd(hr);
		r.day_out = pack_bcd(dy);
		r.month_out = pack_bcd(mo);
		r.year_out = pack_bcd(yr);
		r.bad_month = ~ok;
		return r;
	endfunction

	// ---- driver ----------------------------------------------------------
	// start stays high between back-to-back beats; it drops only in gaps
	task automatic send_reading(input bcmoa_pkg::item_t it);
		// random hold-off before the beat
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_readings.push_back(adjust_reading(it));
	endtask

	function automatic bcmoa_pkg::item_t valid_reading();
		bcmoa_pkg::item_t it;
		it.second_in = pack_bcd(8'($urandom_range(59)));
		it.minute_in = pack_bcd(8'($urandom_range(59)));
		it.hour_in = pack_bcd(8'($urandom_range(23)));
		it.month_in = pack_bcd(8'($urandom_range(1, 12)));
		it.year_in = pack_bcd(8'($urandom_range(99)));
		it.day_in = pack_bcd(8'($urandom_range(1, month_days(unpack_bcd(it.month_in),
			unpack_bcd(it.year_in)))));
		it.offset_minutes = 12'($urandom);
		return it;
	endfunction

	function automatic bcmoa_pkg::item_t make_reading(input logic [7:0] s, mi, h, d, mo, y,
		input int off);
		bcmoa_pkg::item_t it;
		it = '{s, mi, h, d, mo, y, 12'(off)};
		return it;
	endfunction

	// ---- checker ---------------------------------------------------------
	always @(posedge clk) begin
		bcmoa_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: %h", result);
			end else begin
				want = pending_readings.pop_front();
				if (result !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want %h got %h", want, result);
				end
			end
		end
	end

	// watchdog: cycles without any accepted beat or done
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---- tests -----------------------------------------------------------
	task automatic test_directed();
		send_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 0));
		send_reading(make_reading(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 2047));
		send_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, -2048));
		send_reading(make_reading(8'h30, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 1));
		send_reading(make_reading(8'h30, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, -1));
		send_reading(make_reading(8'h10, 8'h30, 8'h23, 8'h28, 8'h02, 8'h24, 60));
		send_reading(make_reading(8'h10, 8'h30, 8'h23, 8'h28, 8'h02, 8'h23, 60));
		send_reading(make_reading(8'h10, 8'h30, 8'h00, 8'h01, 8'h03, 8'h24, -60));
		send_reading(make_reading(8'h10, 8'h30, 8'h00, 8'h01, 8'h03, 8'h25, -60));
		send_reading(make_reading(8'h10, 8'h30, 8'h23, 8'h30, 8'h04, 8'h10, 90));
		// bad month: date frozen
		send_reading(make_reading(8'h10, 8'h30, 8'h23, 8'h31, 8'h00, 8'h10, 2000));
		send_reading(make_reading(8'h10, 8'h30, 8'h00, 8'h01, 8'h13, 8'h10, -2000));
		send_reading(make_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, -1));
		// non-BCD and out-of-range bytes
		send_reading(make_reading(8'hAB, 8'h7C, 8'h30, 8'h00, 8'h05, 8'hA5, -1000));
		send_reading(make_reading(8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, -1500));
		send_reading(make_reading(8'h00, 8'h00, 8'h99, 8'h45, 8'h07, 8'hB0, 1800));
		send_reading(make_reading(8'h00, 8'h00, 8'h22, 8'h31, 8'h12, 8'hA0, 1500));
		send_reading(make_reading(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h09, 8'h55, 1365));
	endtask

	task automatic test_random(input int count, input int gap);
		bcmoa_pkg::item_t it;
		send_gap_pct = gap;
		repeat (count) begin
			if ($urandom_range(9) < 8) begin
				it = valid_reading();
			end else begin
				it = bcmoa_pkg::item_t'(60'({$urandom, $urandom}));
			end
			send_reading(it);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (bcmoa_pkg::LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		send_gap_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100, 0);
		test_random(100, 45);
		test_random(100, 0);
		test_random(100, 15);
		drain_results();
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
